/* src/ofv_pkg.sv */
// Shared constants, types and latency helpers for the orthonormal frame pipeline.
`timescale 1ns / 1ps
package ofv_pkg;

  localparam int unsigned InWidthDef  = 16;
  localparam int unsigned FracBitsDef = 14;
  localparam int unsigned AxisW       = 16;
  localparam int unsigned PerpW       = 15;
  localparam int unsigned ThrW        = 2 * PerpW;
  // Width of a magnitude after alignment, MSB of the largest lane at bit AlignW-1.
  localparam int unsigned AlignW      = 30;
  // Square root pipeline: two result bits per stage over a 64-bit radicand.
  localparam int unsigned SqrtStages  = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRIM_ZERO = 2'd1,
    ST_SEC_ZERO  = 2'd2,
    ST_PARALLEL  = 2'd3
  } ofv_status_e;

  // Two quotient bits per stage, at least FracBits+1 quotient bits.
  function automatic int unsigned div_stages(int unsigned frac);
    return (frac + 2) >> 1;
  endfunction

  // Stages of one normalizer: magnitude, leading zeros, align, squares, sum,
  // square root, divider setup, divider, sign and clamp.
  function automatic int unsigned unit_latency(int unsigned frac);
    return 7 + SqrtStages + div_stages(frac);
  endfunction

endpackage

/* src/ofv_delay.sv */
// Enabled shift line that keeps side data in step with a pipelined unit.
`timescale 1ns / 1ps
module ofv_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] line_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= data_i;
      for (int k = 1; k < Depth; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign data_o = line_q[Depth-1];

endmodule

/* src/ofv_unit3.sv */
// Pipelined normalizer that scales a signed 3-vector to unit length in fixed point.
`timescale 1ns / 1ps
module ofv_unit3 #(
  parameter int unsigned VecW     = 16,
  parameter int unsigned FracBits = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [VecW-1:0]     vec_i [3],
  output logic                       valid_o,
  output logic                       ok_o,
  output logic signed [FracBits+1:0] unit_o [3]
);
  import ofv_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [2:0] neg;
  } side_t;

  localparam int unsigned LzW      = $clog2(VecW);
  localparam int unsigned SqW      = 2 * AlignW;
  localparam int unsigned SumW     = SqW + 2;
  localparam int unsigned RadW     = 4 * SqrtStages;
  localparam int unsigned RootW    = 2 * SqrtStages;
  localparam int unsigned RemW     = RootW + 3;
  localparam int unsigned AlDepth  = SqrtStages + 3;
  localparam int unsigned DivSt    = div_stages(FracBits);
  localparam int unsigned DivSteps = 2 * DivSt;
  localparam int unsigned NumW     = AlignW + FracBits + 1;
  localparam int unsigned DRemW    = RootW + 1;
  localparam int unsigned UW       = FracBits + 2;
  localparam int unsigned Lat      = unit_latency(FracBits);
  localparam logic [DivSteps-1:0] QMax = DivSteps'(1) << FracBits;

  logic [Lat-1:0] vld_q;
  side_t          side_q [Lat];
  side_t          side1_d;

  logic [VecW-1:0]   mag1_q [3];
  logic [VecW-1:0]   mag1_d [3];
  logic [VecW-1:0]   mag2_q [3];
  logic [LzW-1:0]    lz2_q, lz2_d;
  logic [AlignW-1:0] al_q [AlDepth][3];
  logic [AlignW-1:0] al3_d [3];
  logic [SqW-1:0]    sq4_q [3];
  logic [SumW-1:0]   sum5_q, sum5_d;

  logic [RemW-1:0]   srem_q [SqrtStages];
  logic [RemW-1:0]   srem_d [SqrtStages];
  logic [RootW-1:0]  root_q [SqrtStages];
  logic [RootW-1:0]  root_d [SqrtStages];
  logic [RadW-1:0]   rad_q  [SqrtStages];
  logic [RadW-1:0]   rad_d  [SqrtStages];

  logic [RootW-1:0]    dn_q   [DivSt+1];
  logic [DRemW-1:0]    drem_q [DivSt+1][3];
  logic [DRemW-1:0]    drem_d [DivSt+1][3];
  logic [DivSteps-1:0] dlo_q  [DivSt+1][3];
  logic [DivSteps-1:0] dlo_d  [DivSt+1][3];
  logic [DivSteps-1:0] dquo_q [DivSt+1][3];
  logic [DivSteps-1:0] dquo_d [DivSt+1][3];

  logic signed [UW-1:0] unit_q [3];
  logic signed [UW-1:0] unit_d [3];

  // Magnitudes, signs and the zero test.
  always_comb begin
    side1_d.ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      side1_d.neg[i] = vec_i[i][VecW-1];
      mag1_d[i]      = vec_i[i][VecW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
      if (vec_i[i] != '0) begin
        side1_d.ok = 1'b1;
      end
    end
  end

  // The top set bit of the OR of the magnitudes is the top bit of the largest one.
  always_comb begin
    logic [VecW-1:0] orv;
    orv   = mag1_q[0] | mag1_q[1] | mag1_q[2];
    lz2_d = '0;
    for (int b = 0; b < VecW; b++) begin
      if (orv[b]) begin
        lz2_d = LzW'(VecW - 1 - b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [VecW+AlignW-1:0] ext;
      ext      = {mag2_q[i], {AlignW{1'b0}}} << lz2_q;
      al3_d[i] = ext[VecW+AlignW-1 -: AlignW];
    end
  end

  assign sum5_d = SumW'(sq4_q[0]) + SumW'(sq4_q[1]) + SumW'(sq4_q[2]);

  // Digit-by-digit square root, two radicand bit pairs per stage.
  always_comb begin
    for (int j = 0; j < SqrtStages; j++) begin
      logic [RemW-1:0]  r;
      logic [RemW-1:0]  t;
      logic [RootW-1:0] q;
      logic [RadW-1:0]  n;
      if (j == 0) begin
        r = '0;
        q = '0;
        n = RadW'(sum5_q);
      end else begin
        r = srem_q[j-1];
        q = root_q[j-1];
        n = rad_q[j-1];
      end
      for (int k = 0; k < 2; k++) begin
        r = {r[RemW-3:0], n[RadW-1 -: 2]};
        n = n << 2;
        t = {1'b0, q, 2'b01};
        if (r >= t) begin
          r = r - t;
          q = {q[RootW-2:0], 1'b1};
        end else begin
          q = {q[RootW-2:0], 1'b0};
        end
      end
      srem_d[j] = r;
      root_d[j] = q;
      rad_d[j]  = n;
    end
  end

  // Divider setup: the rounding offset is added to the numerator, and the
  // quotient is known to fit, so the upper numerator bits start as remainder.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NumW-1:0] x;
      logic [NumW-1:0] xs;
      x  = NumW'({al_q[AlDepth-1][i], {FracBits{1'b0}}})
         + NumW'(root_q[SqrtStages-1] >> 1);
      xs = x >> DivSteps;
      drem_d[0][i] = DRemW'(xs);
      dlo_d[0][i]  = x[DivSteps-1:0];
      dquo_d[0][i] = '0;
    end
    for (int j = 1; j <= DivSt; j++) begin
      for (int i = 0; i < 3; i++) begin
        logic [DRemW-1:0]    r;
        logic [DivSteps-1:0] lo;
        logic [DivSteps-1:0] q;
        r  = drem_q[j-1][i];
        lo = dlo_q[j-1][i];
        q  = dquo_q[j-1][i];
        for (int k = 0; k < 2; k++) begin
          r  = {r[DRemW-2:0], lo[DivSteps-1]};
          lo = lo << 1;
          if (r >= {1'b0, dn_q[j-1]}) begin
            r = r - {1'b0, dn_q[j-1]};
            q = {q[DivSteps-2:0], 1'b1};
          end else begin
            q = {q[DivSteps-2:0], 1'b0};
          end
        end
        drem_d[j][i] = r;
        dlo_d[j][i]  = lo;
        dquo_d[j][i] = q;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [DivSteps-1:0] q;
      logic [UW-1:0]       m;
      q = (dquo_q[DivSt][i] > QMax) ? QMax : dquo_q[DivSt][i];
      m = UW'(q);
      if (!side_q[Lat-2].ok) begin
        unit_d[i] = '0;
      end else if (side_q[Lat-2].neg[i]) begin
        unit_d[i] = -$signed(m);
      end else begin
        unit_d[i] = $signed(m);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side1_d;
      for (int k = 1; k < Lat; k++) begin
        side_q[k] <= side_q[k-1];
      end
      mag1_q <= mag1_d;
      mag2_q <= mag1_q;
      lz2_q  <= lz2_d;
      al_q[0] <= al3_d;
      for (int k = 1; k < AlDepth; k++) begin
        al_q[k] <= al_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= al_q[0][i] * al_q[0][i];
      end
      sum5_q <= sum5_d;
      srem_q <= srem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      dn_q[0] <= root_q[SqrtStages-1];
      for (int j = 1; j <= DivSt; j++) begin
        dn_q[j] <= dn_q[j-1];
      end
      drem_q <= drem_d;
      dlo_q  <= dlo_d;
      dquo_q <= dquo_d;
      unit_q <= unit_d;
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign ok_o    = side_q[Lat-1].ok;
  assign unit_o  = unit_q;

endmodule

/* src/orthonormal_frame_from_two_vectors.sv */
// Top level: Gram-Schmidt orthonormal frame from a primary and a secondary vector.
//
// Input channel: in_valid_i with the six vector components; a transaction
// completes on a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with nine Q1.FRAC_BITS axis entries and status_o;
// a transaction completes where out_valid_o is high and out_stall_i is low.
// Configuration: cfg_valid_i with cfg_min_perp_norm_i; cfg_ready_o is always
// high, and the squared limit is stored at the write.
// Each normalizer pipeline includes 16 square root stages and the divider
// stages. Throughput is one transaction per cycle while no result is held
// under out_stall_i. The primary and secondary normalizers run side by side,
// the residual normalizer follows the dot product and norm test.
// While a result waits under out_stall_i the whole pipeline holds and
// in_stall_o is raised; nothing is dropped or repeated.
// Reset clears all valid bits and sets the limit back to one.
`timescale 1ns / 1ps
module orthonormal_frame_from_two_vectors #(
  parameter int unsigned InWidth  = ofv_pkg::InWidthDef,
  parameter int unsigned FracBits = ofv_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [InWidth-1:0]         primary_x_i,
  input  logic signed [InWidth-1:0]         primary_y_i,
  input  logic signed [InWidth-1:0]         primary_z_i,
  input  logic signed [InWidth-1:0]         secondary_x_i,
  input  logic signed [InWidth-1:0]         secondary_y_i,
  input  logic signed [InWidth-1:0]         secondary_z_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ofv_pkg::PerpW-1:0]         cfg_min_perp_norm_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_one_x_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_one_y_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_one_z_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_two_x_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_two_y_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_two_z_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_three_x_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_three_y_o,
  output logic signed [ofv_pkg::AxisW-1:0]  axis_three_z_o,
  output logic [1:0]                        status_o
);
  import ofv_pkg::*;

  localparam int unsigned UW   = FracBits + 2;
  localparam int unsigned PW   = 2 * FracBits + 4;
  localparam int unsigned DW   = 2 * FracBits + 6;
  localparam int unsigned QW   = FracBits + 3;
  localparam int unsigned RPW  = 2 * FracBits + 5;
  localparam int unsigned RW   = 2 * FracBits + 3;
  localparam int unsigned BW   = RW + 34;
  localparam int unsigned CW   = 2 * FracBits + 5;
  localparam int unsigned SSW  = 66;
  localparam int unsigned Lat  = unit_latency(FracBits);
  localparam int unsigned SideW = 3 * UW + 2;

  localparam logic [DW-1:0] DHalf = DW'(1) << (FracBits - 1);
  localparam logic [RW:0]   RHalf = (RW + 1)'(1) << (FracBits - 1);
  localparam logic [CW-1:0] CHalf = CW'(1) << (FracBits - 1);
  localparam logic [CW-1:0] COne  = CW'(1) << FracBits;
  localparam logic [BW-1:0] BLim  = BW'(64'h8000_0000);

  logic en;
  logic [ThrW-1:0] thr_q;

  logic signed [InWidth-1:0] pvec [3];
  logic signed [InWidth-1:0] svec [3];
  logic signed [UW-1:0]      pu [3];
  logic signed [UW-1:0]      su [3];
  logic                      p_vld, s_vld, p_ok, s_ok;

  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  ofv_status_e          st1_q, st2_q, st3_q, st4_q, st5_q, st6_q, st7_q;
  ofv_status_e          st1_d, st7_d;
  logic signed [PW-1:0] prod1_q [3];
  logic signed [UW-1:0] u1_q [3], u2_q [3], u3_q [3], u4_q [3], u5_q [3], u6_q [3], u7_q [3];
  logic signed [UW-1:0] s1_q [3], s2_q [3], s3_q [3];
  logic signed [QW-1:0] dq2_q, dq2_d;
  logic signed [RPW-1:0] pr3_q [3];
  logic signed [RW-1:0] r4_q [3], r5_q [3], r6_q [3], r7_q [3];
  logic signed [RW-1:0] r4_d [3];
  logic [31:0]          mq5_q [3];
  logic [31:0]          mq5_d [3];
  logic [63:0]          sq6_q [3];

  logic [SideW-1:0]     side_in, side_out;
  logic signed [UW-1:0] ud [3];
  ofv_status_e          st_r;
  logic                 r_vld, r_ok;
  logic signed [UW-1:0] rv [3];

  logic                 x1_vld_q;
  ofv_status_e          x1_st_q;
  logic signed [UW-1:0] x1_u_q [3], x1_v_q [3];
  logic signed [PW-1:0] ca_q [3], cb_q [3];
  logic signed [UW-1:0] w_d [3];

  logic                 out_vld_q;
  ofv_status_e          out_st_q;
  logic signed [AxisW-1:0] au_q [3], av_q [3], aw_q [3];

  // The whole pipeline advances unless a finished result is held.
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_min_perp_norm_i * cfg_min_perp_norm_i;
    end
  end

  assign pvec[0] = primary_x_i;
  assign pvec[1] = primary_y_i;
  assign pvec[2] = primary_z_i;
  assign svec[0] = secondary_x_i;
  assign svec[1] = secondary_y_i;
  assign svec[2] = secondary_z_i;

  ofv_unit3 #(.VecW(InWidth), .FracBits(FracBits)) u_unit_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(pvec),
    .valid_o(p_vld), .ok_o(p_ok), .unit_o(pu)
  );

  ofv_unit3 #(.VecW(InWidth), .FracBits(FracBits)) u_unit_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(svec),
    .valid_o(s_vld), .ok_o(s_ok), .unit_o(su)
  );

  always_comb begin
    if (!p_ok) begin
      st1_d = ST_PRIM_ZERO;
    end else if (!s_ok) begin
      st1_d = ST_SEC_ZERO;
    end else begin
      st1_d = ST_OK;
    end
  end

  // Dot product rounded back to FracBits fraction bits.
  always_comb begin
    logic signed [DW-1:0] dsum;
    logic [DW-1:0]        dmag;
    dsum  = DW'(prod1_q[0]) + DW'(prod1_q[1]) + DW'(prod1_q[2]);
    dmag  = dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
    dmag  = (dmag + DHalf) >> FracBits;
    dq2_d = dsum[DW-1] ? -$signed(QW'(dmag)) : $signed(QW'(dmag));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [RPW-1:0] sx;
      logic [RW-1:0]         rmag;
      logic [RW:0]           rr;
      logic [BW-1:0]         big;
      sx      = RPW'(s3_q[i]) <<< FracBits;
      r4_d[i] = RW'(sx - pr3_q[i]);
      rmag    = r4_q[i][RW-1] ? RW'(-r4_q[i]) : RW'(r4_q[i]);
      rr      = ({1'b0, rmag} + RHalf) >> FracBits;
      big     = BW'(rr);
      mq5_d[i] = (big > BLim) ? 32'h8000_0000 : big[31:0];
    end
  end

  // Norm test on the rounded residual.
  always_comb begin
    logic [SSW-1:0] ssum;
    ssum = SSW'(sq6_q[0]) + SSW'(sq6_q[1]) + SSW'(sq6_q[2]);
    if (st6_q != ST_OK) begin
      st7_d = st6_q;
    end else if (ssum <= SSW'(thr_q)) begin
      st7_d = ST_PARALLEL;
    end else begin
      st7_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      x1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= p_vld && s_vld;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      x1_vld_q  <= r_vld;
      out_vld_q <= x1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= st1_d;
      st2_q <= st1_q;
      st3_q <= st2_q;
      st4_q <= st3_q;
      st5_q <= st4_q;
      st6_q <= st5_q;
      st7_q <= st7_d;
      dq2_q <= dq2_d;
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= pu[i] * su[i];
        u1_q[i]    <= pu[i];
        s1_q[i]    <= su[i];
        u2_q[i]    <= u1_q[i];
        s2_q[i]    <= s1_q[i];
        pr3_q[i]   <= dq2_q * u2_q[i];
        u3_q[i]    <= u2_q[i];
        s3_q[i]    <= s2_q[i];
        r4_q[i]    <= r4_d[i];
        u4_q[i]    <= u3_q[i];
        mq5_q[i]   <= mq5_d[i];
        r5_q[i]    <= r4_q[i];
        u5_q[i]    <= u4_q[i];
        sq6_q[i]   <= mq5_q[i] * mq5_q[i];
        r6_q[i]    <= r5_q[i];
        u6_q[i]    <= u5_q[i];
        r7_q[i]    <= r6_q[i];
        u7_q[i]    <= u6_q[i];
      end
    end
  end

  assign side_in = {u7_q[0], u7_q[1], u7_q[2], st7_q};

  ofv_delay #(.Width(SideW), .Depth(Lat)) u_side (
    .clk_i, .en_i(en), .data_i(side_in), .data_o(side_out)
  );

  assign ud[0] = side_out[SideW-1 -: UW];
  assign ud[1] = side_out[SideW-1-UW -: UW];
  assign ud[2] = side_out[SideW-1-2*UW -: UW];
  assign st_r  = ofv_status_e'(side_out[1:0]);

  ofv_unit3 #(.VecW(RW), .FracBits(FracBits)) u_unit_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q), .vec_i(r7_q),
    .valid_o(r_vld), .ok_o(r_ok), .unit_o(rv)
  );

  // Cross product entries rounded half away from zero and clamped to one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CW-1:0] diff;
      logic [CW-1:0]        m;
      diff = CW'(ca_q[i]) - CW'(cb_q[i]);
      m    = diff[CW-1] ? CW'(-diff) : CW'(diff);
      m    = (m + CHalf) >> FracBits;
      if (m > COne) begin
        m = COne;
      end
      w_d[i] = diff[CW-1] ? -$signed(UW'(m)) : $signed(UW'(m));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_st_q <= st_r;
      x1_u_q  <= ud;
      x1_v_q  <= rv;
      ca_q[0] <= ud[1] * rv[2];
      cb_q[0] <= ud[2] * rv[1];
      ca_q[1] <= ud[2] * rv[0];
      cb_q[1] <= ud[0] * rv[2];
      ca_q[2] <= ud[0] * rv[1];
      cb_q[2] <= ud[1] * rv[0];
      out_st_q <= x1_st_q;
      for (int i = 0; i < 3; i++) begin
        if (x1_st_q != ST_OK) begin
          au_q[i] <= '0;
          av_q[i] <= '0;
          aw_q[i] <= '0;
        end else begin
          au_q[i] <= AxisW'(x1_u_q[i]);
          av_q[i] <= AxisW'(x1_v_q[i]);
          aw_q[i] <= AxisW'(w_d[i]);
        end
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_st_q;
  assign axis_one_x_o   = au_q[0];
  assign axis_one_y_o   = au_q[1];
  assign axis_one_z_o   = au_q[2];
  assign axis_two_x_o   = av_q[0];
  assign axis_two_y_o   = av_q[1];
  assign axis_two_z_o   = av_q[2];
  assign axis_three_x_o = aw_q[0];
  assign axis_three_y_o = aw_q[1];
  assign axis_three_z_o = aw_q[2];

  // The two front normalizers must stay in lockstep.
  a_front_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld == s_vld)
    else $error("primary and secondary normalizers out of step");

  // A residual that passed the norm test cannot be the zero vector.
  a_residual_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_vld && st_r == ST_OK |-> r_ok)
    else $error("residual passed the norm test but normalized as zero");

  // Error results carry an all-zero frame.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_st_q != ST_OK |->
      au_q[0] == '0 && au_q[1] == '0 && au_q[2] == '0 &&
      av_q[0] == '0 && av_q[1] == '0 && av_q[2] == '0 &&
      aw_q[0] == '0 && aw_q[1] == '0 && aw_q[2] == '0)
    else $error("nonzero axis on an error result");

  // A good result has a nonzero first axis.
  a_ok_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_st_q == ST_OK |->
      au_q[0] != '0 || au_q[1] != '0 || au_q[2] != '0)
    else $error("first axis is zero on a good result");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the orthonormal frame pipeline with a frame predictor.
`timescale 1ns / 1ps
module tb;
  import ofv_pkg::*;

  localparam int unsigned Frac       = FracBitsDef;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 120;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [AxisW-1:0] axis [9];
    ofv_status_e             status;
  } frame_t;

  class frame_scoreboard;
    frame_t             pending [$];
    longint unsigned    perp_limit;
    int                 mismatches;
    int                 frames_checked;
    int                 status_seen [4];
    string              field_name [9] = '{"axis_one_x", "axis_one_y", "axis_one_z",
                                           "axis_two_x", "axis_two_y", "axis_two_z",
                                           "axis_three_x", "axis_three_y",
                                           "axis_three_z"};

    function new();
      perp_limit = 1;
      mismatches = 0;
      frames_checked = 0;
      status_seen = '{0, 0, 0, 0};
    endfunction

    function void set_limit(longint unsigned value);
      perp_limit = value & ((1 << PerpW) - 1);
    endfunction

    function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic longint round_frac(longint v);
      longint unsigned m;
      m = magnitude(v);
      m = (m + (64'd1 << (Frac - 1))) >> Frac;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > n) bitpos >>= 2;
      while (bitpos != 0) begin
        if (n >= root + bitpos) begin
          n -= root + bitpos;
          root = (root >> 1) + bitpos;
        end else begin
          root >>= 1;
        end
        bitpos >>= 2;
      end
      return root;
    endfunction

    // Aligns the magnitudes so the largest sits in [2^29, 2^30), then divides by
    // the floor square root of the aligned sum of squares.
    function automatic bit normalize(input vec3_t v, output vec3_t o);
      longint unsigned m [3];
      longint unsigned peak, sumsq, nrm, q;
      peak = 0;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magnitude(v[i]);
        if (m[i] > peak) peak = m[i];
        o[i] = 0;
      end
      if (peak == 0) return 0;
      while (peak >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] >>= 1;
        peak >>= 1;
      end
      while (peak < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] <<= 1;
        peak <<= 1;
      end
      for (int i = 0; i < 3; i++) sumsq += m[i] * m[i];
      nrm = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << Frac) + nrm / 2) / nrm;
        if (q > (64'd1 << Frac)) q = 64'd1 << Frac;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function automatic frame_t build_frame(vec3_t prim, vec3_t sec);
      frame_t f;
      vec3_t u, s, r, v, w;
      longint one, dot, dq;
      longint unsigned m, resid_sq;
      one = longint'(1) << Frac;
      dot = 0;
      resid_sq = 0;
      f.status = ST_OK;
      v = '{0, 0, 0};
      w = '{0, 0, 0};
      if (!normalize(prim, u)) begin
        f.status = ST_PRIM_ZERO;
      end else if (!normalize(sec, s)) begin
        f.status = ST_SEC_ZERO;
      end else begin
        for (int i = 0; i < 3; i++) dot += u[i] * s[i];
        dq = round_frac(dot);
        for (int i = 0; i < 3; i++) begin
          r[i] = s[i] * one - dq * u[i];
          m = magnitude(round_frac(r[i]));
          if (m > (64'd1 << 31)) m = 64'd1 << 31;
          resid_sq += m * m;
        end
        if (resid_sq <= perp_limit * perp_limit) begin
          f.status = ST_PARALLEL;
        end else begin
          void'(normalize(r, v));
          w[0] = round_frac(u[1] * v[2] - u[2] * v[1]);
          w[1] = round_frac(u[2] * v[0] - u[0] * v[2]);
          w[2] = round_frac(u[0] * v[1] - u[1] * v[0]);
          for (int i = 0; i < 3; i++) begin
            if (w[i] > one) w[i] = one;
            if (w[i] < -one) w[i] = -one;
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (f.status != ST_OK) begin
          u[i] = 0;
          v[i] = 0;
          w[i] = 0;
        end
        f.axis[i]     = u[i][AxisW-1:0];
        f.axis[3 + i] = v[i][AxisW-1:0];
        f.axis[6 + i] = w[i][AxisW-1:0];
      end
      return f;
    endfunction

    function void note_input(vec3_t prim, vec3_t sec);
      pending.insert(pending.size(), build_frame(prim, sec));
    endfunction

    function void check_result(frame_t got);
      frame_t want;
      if (pending.size() == 0) begin
        $display("%0t: frame received with none outstanding", $time);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      frames_checked++;
      status_seen[got.status]++;
      for (int i = 0; i < 9; i++) begin
        if (got.axis[i] !== want.axis[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                   want.axis[i], got.axis[i]);
          mismatches++;
        end
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %s actual %0d", $time, want.status.name(),
                 got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [InWidthDef-1:0] primary_x_i, primary_y_i, primary_z_i;
  logic signed [InWidthDef-1:0] secondary_x_i, secondary_y_i, secondary_z_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [PerpW-1:0]         cfg_min_perp_norm_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [AxisW-1:0]  axis_one_x_o, axis_one_y_o, axis_one_z_o;
  logic signed [AxisW-1:0]  axis_two_x_o, axis_two_y_o, axis_two_z_o;
  logic signed [AxisW-1:0]  axis_three_x_o, axis_three_y_o, axis_three_z_o;
  logic [1:0]               status_o;

  frame_scoreboard frames = new();
  int unsigned     cycle_count;
  int              stall_left;
  int              calm_left;

  orthonormal_frame_from_two_vectors dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .primary_x_i         (primary_x_i),
    .primary_y_i         (primary_y_i),
    .primary_z_i         (primary_z_i),
    .secondary_x_i       (secondary_x_i),
    .secondary_y_i       (secondary_y_i),
    .secondary_z_i       (secondary_z_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_min_perp_norm_i (cfg_min_perp_norm_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .axis_one_x_o        (axis_one_x_o),
    .axis_one_y_o        (axis_one_y_o),
    .axis_one_z_o        (axis_one_z_o),
    .axis_two_x_o        (axis_two_x_o),
    .axis_two_y_o        (axis_two_y_o),
    .axis_two_z_o        (axis_two_z_o),
    .axis_three_x_o      (axis_three_x_o),
    .axis_three_y_o      (axis_three_y_o),
    .axis_three_z_o      (axis_three_z_o),
    .status_o            (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input and output transactions are sampled at the edge, before any update.
  always @(posedge clk_i) begin
    frame_t got;
    vec3_t  prim, sec;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      prim = '{primary_x_i, primary_y_i, primary_z_i};
      sec  = '{secondary_x_i, secondary_y_i, secondary_z_i};
      frames.note_input(prim, sec);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.axis = '{axis_one_x_o, axis_one_y_o, axis_one_z_o,
                   axis_two_x_o, axis_two_y_o, axis_two_z_o,
                   axis_three_x_o, axis_three_y_o, axis_three_z_o};
      got.status = ofv_status_e'(status_o);
      frames.check_result(got);
    end
  end

  // Receiver back-pressure, with calm stretches where it never stalls.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      calm_left <= $urandom_range(50, 300);
      out_stall_i <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic drive_pair(vec3_t prim, vec3_t sec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    primary_x_i   <= InWidthDef'(prim[0]);
    primary_y_i   <= InWidthDef'(prim[1]);
    primary_z_i   <= InWidthDef'(prim[2]);
    secondary_x_i <= InWidthDef'(sec[0]);
    secondary_y_i <= InWidthDef'(sec[1]);
    secondary_z_i <= InWidthDef'(sec[2]);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_frames();
    in_valid_i <= 1'b0;
    while (frames.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned value);
    cfg_valid_i         <= 1'b1;
    cfg_min_perp_norm_i <= PerpW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.set_limit(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint any_word();
    return longint'($signed(16'($urandom)));
  endfunction

  function automatic longint near_value(int span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  task automatic random_pair();
    vec3_t prim, sec;
    longint k;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      prim[i] = any_word();
      sec[i]  = any_word();
    end
    case (mode)
      4: begin
        for (int i = 0; i < 3; i++) begin
          prim[i] = near_value(3);
          sec[i]  = near_value(3);
        end
      end
      5, 6: begin
        // Nearly parallel or antiparallel pairs probe the limit test.
        k = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) k = -k;
        for (int i = 0; i < 3; i++) begin
          prim[i] = near_value(8000);
          sec[i]  = prim[i] * k + near_value($urandom_range(0, 3) == 0 ? 200 : 3);
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) begin
          prim[i] = ($urandom_range(0, 2) == 0) ? -32768 : 0;
          sec[i]  = ($urandom_range(0, 2) == 0) ? 32767 : near_value(1);
        end
        if ($urandom_range(0, 3) == 0) prim = '{0, 0, 0};
        if ($urandom_range(0, 3) == 0) sec = '{0, 0, 0};
      end
      8: begin
        prim = '{near_value(30000), near_value(30000), 0};
        sec  = '{-prim[1], prim[0], near_value(100)};
      end
      9: begin
        for (int i = 0; i < 3; i++) begin
          prim[i] = longint'(1) << $urandom_range(0, 14);
          if ($urandom_range(0, 1)) prim[i] = -prim[i];
        end
      end
      default: begin
      end
    endcase
    drive_pair(prim, sec);
  endtask

  initial begin
    int unsigned phase_limit [5] = '{0, 16384, 200, 3, 0};
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    primary_x_i         <= '0;
    primary_y_i         <= '0;
    primary_z_i         <= '0;
    secondary_x_i       <= '0;
    secondary_y_i       <= '0;
    secondary_z_i       <= '0;
    cfg_valid_i         <= 1'b0;
    cfg_min_perp_norm_i <= '0;
    out_stall_i         <= 1'b0;
    cycle_count         <= 0;
    stall_left          <= 0;
    calm_left           <= 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs under the reset limit.
    drive_pair('{1, 0, 0}, '{0, 1, 0});
    drive_pair('{32767, 32767, 32767}, '{-32768, -32768, -32768});
    drive_pair('{-32768, 0, 0}, '{0, 0, 32767});
    drive_pair('{0, 0, 0}, '{1, 2, 3});
    drive_pair('{0, 0, 0}, '{0, 0, 0});
    drive_pair('{5, -7, 9}, '{0, 0, 0});
    drive_pair('{3, 4, 0}, '{6, 8, 0});
    drive_pair('{3, 4, 0}, '{-6, -8, 0});
    drive_pair('{3, 4, 0}, '{6, 8, 1});
    drive_pair('{1, 1, 1}, '{1, 1, 2});
    drive_pair('{-32768, 32767, -1}, '{32767, -32768, 1});
    drive_pair('{0, -1, 0}, '{-1, 0, 0});
    drive_pair('{32767, -32768, 0}, '{0, 0, -32768});
    drive_pair('{1, 0, 0}, '{32767, 1, 0});
    drive_pair('{-1, -1, -1}, '{1, -1, 0});
    drive_pair('{12345, -23456, 7890}, '{-3210, 4321, 30000});
    drain_frames();

    foreach (phase_limit[ph]) begin
      if (ph == 3) write_limit($urandom_range(1, 16383));
      else write_limit(phase_limit[ph]);
      repeat (270) random_pair();
      drain_frames();
    end

    repeat (DrainWait) @(posedge clk_i);
    $display("Checked %0d frames over six limit settings: %0d ok, %0d primary zero,",
             frames.frames_checked, frames.status_seen[0], frames.status_seen[1]);
    $display("%0d secondary zero, %0d parallel.", frames.status_seen[2],
             frames.status_seen[3]);
    if (frames.mismatches == 0 && frames.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
